// ===== hw/rtl/pci_pkg.sv =====
// shared types and constants of the pulse charge integrator
package pci_pkg;

  localparam int IN_W       = 16;
  localparam int OUT_W      = 88;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD      = 3'd0,
    REG_BASELINE_WINDOW = 3'd1,
    REG_GATE_LENGTH    = 3'd2,
    REG_HOLDOFF_LENGTH = 3'd3,
    REG_TAP_DELAY      = 3'd4
  } cfg_reg_t;

  localparam logic [14:0] THRESHOLD_RST       = 15'd5;
  localparam logic [7:0]  BASELINE_WINDOW_RST = 8'd128;
  localparam logic [15:0] GATE_LENGTH_RST     = 16'd2500;
  localparam logic [15:0] HOLDOFF_LENGTH_RST  = 16'd3000;
  localparam logic [7:0]  TAP_DELAY_RST       = 8'd250;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/pulse_charge_integrator.sv =====
// top level: sequencer, window and delay memories, trigger, gate and charge logic
// baseline samples: read, drop, drop, push, divider start and wait, trigger, finish;
//   the radix-2 divider forms the window mean
// gated or held-off samples: read, gate, finish
// one word at a time; input ready only in idle, output register holds one result
// rst is synchronous; clears all record state, restores register defaults
module pulse_charge_integrator #(
  parameter int WINDOW_DEPTH  = 128,
  parameter int DELAY_DEPTH   = 256,
  parameter int RECORD_LENGTH = 8192
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pci_pkg::IN_W-1:0]            s_tdata,  // sample
  input  logic                                s_tlast,  // last
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // trigger_bit, gate_bit, holdoff_bit, stop_bit, peak, charge, gate_baseline,
  // first_trigger_index, trigger_seen, zero fill
  output logic [pci_pkg::OUT_W-1:0]           m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pci_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pci_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pci_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = 16 + CNT_W;
  localparam int WA_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int DA_W   = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int FILL_W = $clog2(DELAY_DEPTH + 1);
  localparam int IDX_W  = $clog2(RECORD_LENGTH);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_RD    = 10'b0000000010,
    ST_DROP1 = 10'b0000000100,
    ST_DROP2 = 10'b0000001000,
    ST_PUSH  = 10'b0000010000,
    ST_DIVGO = 10'b0000100000,
    ST_DIVW  = 10'b0001000000,
    ST_TRIG  = 10'b0010000000,
    ST_GATE  = 10'b0100000000,
    ST_FIN   = 10'b1000000000
  } state_t;

  state_t state;

  logic [14:0] threshold;
  logic [7:0]  baseline_window;
  logic [15:0] gate_length;
  logic [15:0] holdoff_length;
  logic [7:0]  tap_delay;

  logic signed [15:0]      s_reg;
  logic                    last_reg;
  logic signed [SUM_W-1:0] wsum;
  logic [CNT_W-1:0]        wcount;
  logic [WA_W-1:0]         wptr;
  logic [DA_W-1:0]         dptr;
  logic [FILL_W-1:0]       fill;
  logic signed [15:0]      baseline;
  logic                    trig_f;
  logic                    gate_f;
  logic                    hold_f;
  logic                    stop_f;
  logic [15:0]             gcnt;
  logic [15:0]             hcnt;
  logic signed [31:0]      charge;
  logic [14:0]             peak;
  logic signed [15:0]      held_gb;
  logic [IDX_W-1:0]        first_index;
  logic                    seen;
  logic [IDX_W-1:0]        sample_index;
  logic                    trig_hit;

  logic [15:0]             win_rdata;
  logic [15:0]             dly_rdata;
  logic [WA_W-1:0]         win_raddr;
  logic [DA_W-1:0]         dly_raddr;
  logic [DA_W-1:0]         dsel;
  logic [CNT_W-1:0]        n_eff;
  logic signed [SUM_W-1:0] acc_op;
  logic signed [SUM_W-1:0] acc;
  logic signed [15:0]      delayed;
  logic signed [33:0]      charge_wide;
  logic signed [31:0]      charge_sat;
  logic signed [16:0]      trig_diff;
  logic                    trig_new;
  logic                    gate_new;
  logic                    hold_new;
  logic [14:0]             peak_new;
  logic [31:0]             fi_ext;
  logic                    out_free;
  logic [WA_W-1:0]         wptr_inc;
  logic [DA_W-1:0]         dptr_inc;

  div_stat_t          div_stat;
  logic signed [15:0] div_mean;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // effective window length and delay tap
  always_comb begin
    int bw;
    int dd;
    bw = int'(baseline_window);
    if (bw == 0) begin
      bw = 1;
    end else if (bw > WINDOW_DEPTH) begin
      bw = WINDOW_DEPTH;
    end
    n_eff = CNT_W'(bw);
    dd = int'(tap_delay);
    if (dd > DELAY_DEPTH - 1) begin
      dd = DELAY_DEPTH - 1;
    end
    dsel = DA_W'(dd);
  end

  // memory addresses with wrap at the memory depth
  always_comb begin
    int t;
    int u;
    if (state == ST_RD) begin
      t = int'(wptr) - int'(wcount);
    end else begin
      t = int'(wptr) - int'(wcount) + 1;
    end
    if (t < 0) begin
      t = t + WINDOW_DEPTH;
    end else if (t >= WINDOW_DEPTH) begin
      t = t - WINDOW_DEPTH;
    end
    win_raddr = WA_W'(t);
    u = int'(dptr) - int'(dsel);
    if (u < 0) begin
      u = u + DELAY_DEPTH;
    end
    dly_raddr = DA_W'(u);
  end

  assign wptr_inc = (int'(wptr) == WINDOW_DEPTH - 1) ? '0 : wptr + 1'b1;
  assign dptr_inc = (int'(dptr) == DELAY_DEPTH - 1) ? '0 : dptr + 1'b1;

  // shared window accumulator: subtract dropped words, add the new sample
  assign acc_op = (state == ST_PUSH) ? SUM_W'(s_reg) : -SUM_W'($signed(win_rdata));
  assign acc    = wsum + acc_op;

  // delayed sample and saturating charge
  always_comb begin
    if (dsel == '0) begin
      delayed = s_reg;
    end else if (int'(dsel) <= int'(fill)) begin
      delayed = $signed(dly_rdata);
    end else begin
      delayed = '0;
    end
    charge_wide = 34'(charge) + 34'(delayed) - 34'(baseline);
    if (charge_wide[33:31] == 3'b000 || charge_wide[33:31] == 3'b111) begin
      charge_sat = charge_wide[31:0];
    end else if (charge_wide[33]) begin
      charge_sat = 32'sh8000_0000;
    end else begin
      charge_sat = 32'sh7fff_ffff;
    end
  end

  assign trig_diff = 17'(s_reg) - 17'(div_mean);
  assign trig_new  = trig_diff > $signed({2'b00, threshold});

  assign hold_new = trig_hit || (hold_f && (hcnt < holdoff_length));
  assign gate_new = trig_hit || (gate_f && (gcnt < gate_length));
  assign peak_new = (!s_reg[15] && (s_reg != '0) && (s_reg[14:0] > peak)) ? s_reg[14:0]
                                                                           : peak;
  assign fi_ext   = 32'(first_index);

  pci_ram #(.WIDTH(16), .DEPTH(WINDOW_DEPTH)) u_win_ram (
    .clk   (clk),
    .we    (state == ST_PUSH),
    .waddr (wptr),
    .wdata (s_reg),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  pci_ram #(.WIDTH(16), .DEPTH(DELAY_DEPTH)) u_dly_ram (
    .clk   (clk),
    .we    (state == ST_RD),
    .waddr (dptr),
    .wdata (s_reg),
    .raddr (dly_raddr),
    .rdata (dly_rdata)
  );

  pci_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_DIVGO),
    .sum   (wsum),
    .cnt   (wcount),
    .stat  (div_stat),
    .mean  (div_mean)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= THRESHOLD_RST;
      baseline_window <= BASELINE_WINDOW_RST;
      gate_length     <= GATE_LENGTH_RST;
      holdoff_length  <= HOLDOFF_LENGTH_RST;
      tap_delay       <= TAP_DELAY_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD:       threshold       <= cfg_data[14:0];
        REG_BASELINE_WINDOW: baseline_window <= cfg_data[7:0];
        REG_GATE_LENGTH:     gate_length     <= cfg_data;
        REG_HOLDOFF_LENGTH:  holdoff_length  <= cfg_data;
        REG_TAP_DELAY:       tap_delay       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // payload capture and output word
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      s_reg    <= $signed(s_tdata);
      last_reg <= s_tlast;
    end
    if (state == ST_FIN && out_free) begin
      m_tdata <= {7'b0, seen, fi_ext[12:0], held_gb, charge, peak_new,
                  stop_f, hold_f, gate_f, trig_f};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // sequencer and record state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      wsum         <= '0;
      wcount       <= '0;
      wptr         <= '0;
      dptr         <= '0;
      fill         <= '0;
      baseline     <= '0;
      trig_f       <= 1'b0;
      gate_f       <= 1'b0;
      hold_f       <= 1'b0;
      stop_f       <= 1'b0;
      gcnt         <= '0;
      hcnt         <= '0;
      charge       <= '0;
      peak         <= '0;
      held_gb      <= '0;
      first_index  <= '0;
      seen         <= 1'b0;
      sample_index <= '0;
      trig_hit     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          trig_hit <= 1'b0;
          state    <= (!gate_f && !hold_f) ? ST_DROP1 : ST_GATE;
        end
        ST_DROP1: begin
          if (wcount >= n_eff) begin
            wsum   <= acc;
            wcount <= wcount - 1'b1;
          end
          state <= ST_DROP2;
        end
        ST_DROP2: begin
          if (wcount >= n_eff) begin
            wsum   <= acc;
            wcount <= wcount - 1'b1;
          end
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          wsum   <= acc;
          wcount <= wcount + 1'b1;
          wptr   <= wptr_inc;
          state  <= ST_DIVGO;
        end
        ST_DIVGO: begin
          state <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_stat.done) begin
            state <= ST_TRIG;
          end
        end
        ST_TRIG: begin
          baseline <= div_mean;
          trig_hit <= trig_new;
          if (trig_new && !seen) begin
            seen        <= 1'b1;
            first_index <= sample_index;
          end
          state <= ST_FIN;
        end
        ST_GATE: begin
          if (gate_f) begin
            charge  <= charge_sat;
            held_gb <= baseline;
            if (gcnt != 16'hffff) begin
              gcnt <= gcnt + 1'b1;
            end
          end
          if (hold_f && hcnt != 16'hffff) begin
            hcnt <= hcnt + 1'b1;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (last_reg) begin
              wsum         <= '0;
              wcount       <= '0;
              wptr         <= '0;
              dptr         <= '0;
              fill         <= '0;
              baseline     <= '0;
              trig_f       <= 1'b0;
              gate_f       <= 1'b0;
              hold_f       <= 1'b0;
              stop_f       <= 1'b0;
              gcnt         <= '0;
              hcnt         <= '0;
              charge       <= '0;
              peak         <= '0;
              held_gb      <= '0;
              first_index  <= '0;
              seen         <= 1'b0;
              sample_index <= '0;
            end else begin
              trig_f <= trig_hit;
              gate_f <= gate_new;
              hold_f <= hold_new;
              stop_f <= seen && !gate_new && !hold_new;
              if (trig_hit) begin
                gcnt <= '0;
                hcnt <= '0;
              end
              peak <= peak_new;
              dptr <= dptr_inc;
              if (int'(fill) < DELAY_DEPTH) begin
                fill <= fill + 1'b1;
              end
              if (int'(sample_index) < RECORD_LENGTH - 1) begin
                sample_index <= sample_index + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/pci_ram.sv =====
// generic simple dual-port ram with registered read
module pci_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pci_div.sv =====
// radix-2 restoring divider forming the rounded mean of the baseline window
module pci_div #(
  parameter int SUM_W = 24,
  parameter int CNT_W = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sum,
  input  logic [CNT_W-1:0]        cnt,
  output pci_pkg::div_stat_t      stat,
  output logic signed [15:0]      mean
);
  import pci_pkg::*;

  localparam int NUM_W  = SUM_W + 1;
  localparam int DEN_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic              neg;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;

  logic [SUM_W-1:0]  mag;
  logic [NUM_W-1:0]  num;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign num   = {mag, 1'b0} + NUM_W'(cnt);
  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo   <= num;
        rem   <= '0;
        den   <= {cnt, 1'b0};
        neg   <= sum[SUM_W-1];
        steps <= STEP_W'(NUM_W);
        busy  <= 1'b1;
      end else if (busy) begin
        quo   <= {quo[NUM_W-2:0], ge};
        rem   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign mean      = neg ? -$signed(quo[15:0]) : $signed(quo[15:0]);

endmodule

// ===== tb/pulse_charge_integrator_test.sv =====
// testbench for pulse_charge_integrator: random and directed sample records checked by a predictor
module pulse_charge_integrator_test;
  import pci_pkg::*;

  localparam int WIN_DEPTH = 128;
  localparam int DLY_DEPTH = 256;
  localparam int REC_LEN = 8192;
  localparam int RANDOM_ITEMS = 1800;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam longint CHARGE_MAX = 64'sd2147483647;
  localparam longint CHARGE_MIN = -CHARGE_MAX - 1;

  typedef struct packed {
    logic [6:0] pad;
    logic seen;
    logic [12:0] first_idx;
    logic signed [15:0] gate_base;
    logic signed [31:0] charge;
    logic [14:0] peak;
    logic stop;
    logic hold;
    logic gate;
    logic trig;
  } pulse_result_t;

  class charge_scoreboard;
    int thr, win, gate_len, hold_len, offs;
    int win_store[WIN_DEPTH];
    longint win_sum;
    int win_count, win_ptr;
    int delay_mem[DLY_DEPTH];
    int delay_ptr, baseline, gate_cnt, hold_cnt, charge, peak, gated_base, first_idx, index;
    bit trig_f, gate_f, hold_f, stop_f, seen;
    pulse_result_t expected_q[$];
    int samples, records, triggers, saturated, writes, checked, errors;

    function new();
      thr = THRESHOLD_RST;
      win = BASELINE_WINDOW_RST;
      gate_len = GATE_LENGTH_RST;
      hold_len = HOLDOFF_LENGTH_RST;
      offs = TAP_DELAY_RST;
      clear_record();
    endfunction

    function void clear_record();
      foreach (win_store[i]) win_store[i] = 0;
      foreach (delay_mem[i]) delay_mem[i] = 0;
      win_sum = 0;
      win_count = 0;
      win_ptr = 0;
      delay_ptr = 0;
      baseline = 0;
      {trig_f, gate_f, hold_f, stop_f} = 4'b0000;
      gate_cnt = 0;
      hold_cnt = 0;
      charge = 0;
      peak = 0;
      gated_base = 0;
      first_idx = 0;
      seen = 1'b0;
      index = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [15:0] v);
      writes++;
      case (idx)
        REG_THRESHOLD: thr = v[14:0];
        REG_BASELINE_WINDOW: win = v[7:0];
        REG_GATE_LENGTH: gate_len = v;
        REG_HOLDOFF_LENGTH: hold_len = v;
        REG_TAP_DELAY: offs = v[7:0];
        default: ;
      endcase
    endfunction

    function void drop_oldest();
      win_sum -= win_store[(win_ptr + WIN_DEPTH - win_count) % WIN_DEPTH];
      win_count--;
    endfunction

    function void note_sample(logic [15:0] s, logic last);
      pulse_result_t r;
      int sv, d, n, delayed;
      bit trig, gate, hold;
      longint c, mag, q;
      sv = $signed(s);
      trig = trig_f;
      gate = gate_f;
      hold = hold_f;
      r = '0;
      r.trig = trig_f;
      r.gate = gate_f;
      r.hold = hold_f;
      r.stop = stop_f;
      if (sv > peak) peak = sv;
      d = offs < DLY_DEPTH ? offs : DLY_DEPTH - 1;
      delay_mem[delay_ptr] = sv;
      delayed = delay_mem[(delay_ptr + DLY_DEPTH - d) % DLY_DEPTH];
      delay_ptr = (delay_ptr + 1) % DLY_DEPTH;
      if (!gate && !hold) begin
        n = win == 0 ? 1 : win;
        if (n > WIN_DEPTH) n = WIN_DEPTH;
        if (win_count >= n) drop_oldest();
        if (win_count >= n) drop_oldest();
        win_store[win_ptr] = sv;
        win_sum += sv;
        win_count++;
        win_ptr = (win_ptr + 1) % WIN_DEPTH;
        // mean rounded half away from zero
        mag = win_sum < 0 ? -win_sum : win_sum;
        q = (2 * mag + win_count) / (2 * win_count);
        baseline = win_sum < 0 ? -int'(q) : int'(q);
        trig = (sv - baseline) > thr;
        if (trig && !seen) begin
          seen = 1'b1;
          first_idx = index;
        end
      end else begin
        if (gate) begin
          c = longint'(charge) + delayed - baseline;
          if (c > CHARGE_MAX) c = CHARGE_MAX;
          if (c < CHARGE_MIN) c = CHARGE_MIN;
          charge = int'(c);
          gated_base = baseline;
          if (gate_cnt < 65535) gate_cnt++;
        end
        if (hold && hold_cnt < 65535) hold_cnt++;
        trig = 1'b0;
      end
      if (trig) begin
        gate_cnt = 0;
        hold_cnt = 0;
        triggers++;
      end
      hold = trig || (hold && hold_cnt < hold_len);
      gate = trig || (gate && gate_cnt < gate_len);
      trig_f = trig;
      gate_f = gate;
      hold_f = hold;
      stop_f = seen && !gate && !hold;
      r.peak = peak[14:0];
      r.charge = charge;
      r.gate_base = gated_base[15:0];
      r.first_idx = first_idx[12:0];
      r.seen = seen;
      if (charge == CHARGE_MAX || charge == CHARGE_MIN) saturated++;
      if (index < REC_LEN - 1) index++;
      samples++;
      if (last) begin
        records++;
        clear_record();
      end
      expected_q.insert(expected_q.size(), r);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, longint got, longint want);
      if (got != want)
        report($sformatf("word %0d %s: got %0d expected %0d", checked, name, got, want));
    endtask

    task check_result(pulse_result_t got);
      pulse_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("word %0d arrived with no sample outstanding", checked));
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      if ($isunknown(got)) begin
        report($sformatf("word %0d has unknown bits: %h", checked, got));
        return;
      end
      compare_field("trigger_bit", got.trig, want.trig);
      compare_field("gate_bit", got.gate, want.gate);
      compare_field("holdoff_bit", got.hold, want.hold);
      compare_field("stop_bit", got.stop, want.stop);
      compare_field("peak", got.peak, want.peak);
      compare_field("charge", got.charge, want.charge);
      compare_field("gate_baseline", got.gate_base, want.gate_base);
      compare_field("first_trigger_index", got.first_idx, want.first_idx);
      compare_field("trigger_seen", got.seen, want.seen);
      compare_field("zero fill", got.pad, 0);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  bit long_hold = 1'b0;
  int quiet_cycles = 0;
  charge_scoreboard sb;

  pulse_charge_integrator #(
    .WINDOW_DEPTH(WIN_DEPTH),
    .DELAY_DEPTH(DLY_DEPTH),
    .RECORD_LENGTH(REC_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (s_tvalid && s_tready) sb.note_sample(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d words outstanding",
                 QUIET_LIMIT, sb.pending());
        $display("status: fail");
        $finish;
      end
    end
  end

  // output side: short random stalls, plus one long hold on request
  initial begin : receiver
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        stall = 300;
      end else if (stall == 0 && rx_idling && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10);
      end
      if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic send_sample(input int value, input logic last);
    int gap;
    gap = (tx_idling && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = value[15:0];
    s_tlast = last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value[15:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(input int thr, input int win, input int glen, input int hlen,
                               input int offs);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_BASELINE_WINDOW, win);
    write_reg(REG_GATE_LENGTH, glen);
    write_reg(REG_HOLDOFF_LENGTH, hlen);
    write_reg(REG_TAP_DELAY, offs);
  endtask

  function automatic int pick(int lo, int hi, int typical_hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, typical_hi);
    endcase
  endfunction

  function automatic int pick_sample(int level, int noise, int pulse_odds);
    int v;
    if ($urandom_range(0, 15) == 0) return int'($urandom_range(0, 65535)) - 32768;
    v = level + int'($urandom_range(0, 2 * noise)) - noise;
    if (int'($urandom_range(0, 99)) < pulse_odds) v += int'($urandom_range(50, 20000));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  initial begin : stimulus
    int random_sent, phase, rec_left, level, noise, pulse_odds, burst;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // register defaults: early trigger, delayed data from before the record
    send_sample(0, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(-1, 1'b1);

    // all registers at minimum: window of one, gate of one sample
    drain();
    apply_setting(0, 0, 0, 0, 0);
    send_sample(5, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(7, 1'b1);

    drain();
    write_reg(REG_BASELINE_WINDOW, 2);
    send_sample(100, 1'b0);
    send_sample(200, 1'b0);
    send_sample(-300, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(12, 1'b1);

    // window shrunk in the middle of a record
    drain();
    apply_setting(1000, 6, 2, 3, 1);
    send_sample(-2, 1'b0);
    send_sample(3, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(4, 1'b0);
    send_sample(0, 1'b0);
    send_sample(2, 1'b0);
    drain();
    write_reg(REG_BASELINE_WINDOW, 2);
    send_sample(-7, 1'b0);
    send_sample(8, 1'b0);
    send_sample(0, 1'b0);
    send_sample(3, 1'b1);

    // all registers at maximum, window above depth
    drain();
    apply_setting(32767, 255, 65535, 65535, 255);
    send_sample(-32768, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(32767, 1'b1);

    random_sent = 0;
    phase = 0;
    rec_left = $urandom_range(1, 150);
    while (random_sent < RANDOM_ITEMS) begin
      drain();
      apply_setting(pick(0, 32767, 400), pick(0, 255, 128), pick(0, 65535, 40),
                    pick(0, 65535, 60), pick(0, 255, 255));
      tx_idling = random_sent < RANDOM_ITEMS - 400;
      rx_idling = tx_idling;
      level = int'($urandom_range(0, 60000)) - 30000;
      noise = $urandom_range(0, 40);
      pulse_odds = $urandom_range(1, 12);
      burst = $urandom_range(80, 220);
      for (int i = 0; i < burst; i++) begin
        if (phase == 2 && i == 10) long_hold = 1'b1;
        send_sample(pick_sample(level, noise, pulse_odds), rec_left == 1);
        rec_left = (rec_left == 1) ? $urandom_range(1, 150) : rec_left - 1;
      end
      random_sent += burst;
      phase++;
    end
    send_sample(0, 1'b1);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d samples in %0d records, %0d triggers, %0d words at a charge limit",
             sb.samples, sb.records, sb.triggers, sb.saturated);
    $display("%0d register writes, %0d words checked, %0d mismatches",
             sb.writes, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/pci_pkg.sv
hw/rtl/pci_ram.sv
hw/rtl/pci_div.sv
hw/rtl/pulse_charge_integrator.sv
tb/pulse_charge_integrator_test.sv
